// File: rtl/worst_fit_partition_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// worst-fit partition allocator assertion macros
// shared helpers for concurrent checks, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef WORST_FIT_PARTITION_ALLOCATOR_TOP_ASSERT_SVH
`define WORST_FIT_PARTITION_ALLOCATOR_TOP_ASSERT_SVH

// condition holds at every edge
`define WFPA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define WFPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define WFPA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wfpa_pkg.sv
// ----------------------------------------------------------------------------
// wfpa_pkg
// constants, operation codes and control types of the partition allocator
// ----------------------------------------------------------------------------
`default_nettype none

package wfpa_pkg;

  // table geometry
  localparam int PARTITIONS = 8;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = $clog2(PARTITIONS);

  // field widths
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 3;
  localparam int AMOUNT_W = 16;
  localparam int CHOSEN_W = 3;
  localparam int LEFT_W   = 16;
  localparam int TOT_W    = 19;

  localparam int TOTAL_MAX = 524280;

  // internal arithmetic widths
  localparam int CMP_W   = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;
  localparam int ACC_BITS = SIZE_BITS + IDX_BITS;
  localparam int EXT_W   = (ACC_BITS > TOT_W) ? ACC_BITS : TOT_W;
  localparam int INS_W   = ((SIZE_BITS > TOT_W) ? SIZE_BITS : TOT_W) + 1;

  // stream widths
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = OP_W;
  localparam int M_TDATA_W = 64;
  localparam int M_TUSER_W = 1;
  localparam int M_PAD_W   = M_TDATA_W - (CHOSEN_W + LEFT_W + TOT_W + TOT_W);

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic take;       // latch item, restart scan
    logic apply;      // perform load or clear
    logic scan_step;  // visit one partition
    logic commit;     // update table and capture result
  } wfpa_cmd_t;

  typedef struct packed {
    logic scan_last;  // scan is at the last partition
  } wfpa_status_t;

endpackage

`default_nettype wire

// File: rtl/wfpa_ctrl.sv
// ----------------------------------------------------------------------------
// wfpa_ctrl
// sequencer for item intake, table update, partition scan and result transfer
// ----------------------------------------------------------------------------
`default_nettype none

`include "worst_fit_partition_allocator_top_assert.svh"

module wfpa_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [wfpa_pkg::OP_W-1:0]      op,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output wfpa_pkg::wfpa_cmd_t            cmd,
  input  wfpa_pkg::wfpa_status_t         status
);
  import wfpa_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_APPLY  = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       m_tvalid_next;

  always_comb begin
    state_next    = state;
    m_tvalid_next = m_tvalid;
    cmd           = '0;
    s_tready      = (state == S_IDLE);
    if (m_tvalid && m_tready) begin
      m_tvalid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = (op == OP_ALLOC || op == OP_REPORT) ? S_SCAN : S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!m_tvalid || m_tready) begin
          cmd.commit    = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  `WFPA_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "item accepted while busy")
  `WFPA_ASSERT_NXT(a_scan_end, state == S_SCAN && status.scan_last, state == S_COMMIT, "scan end")
  `WFPA_ASSERT_IMP(a_no_overrun, cmd.commit, !m_tvalid || m_tready, "result overwritten")

endmodule

`default_nettype wire

// File: rtl/wfpa_datapath.sv
// ----------------------------------------------------------------------------
// wfpa_datapath
// partition table, worst-fit scan, totals and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "worst_fit_partition_allocator_top_assert.svh"

module wfpa_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  wfpa_pkg::wfpa_cmd_t               cmd,
  output wfpa_pkg::wfpa_status_t            status,
  input  logic [wfpa_pkg::OP_W-1:0]         op,
  input  logic [wfpa_pkg::SLOT_W-1:0]       slot,
  input  logic [wfpa_pkg::AMOUNT_W-1:0]     amount,
  output logic                              res_granted,
  output logic [wfpa_pkg::CHOSEN_W-1:0]     res_chosen,
  output logic [wfpa_pkg::LEFT_W-1:0]       res_leftover,
  output logic [wfpa_pkg::TOT_W-1:0]        res_internal,
  output logic [wfpa_pkg::TOT_W-1:0]        res_external
);
  import wfpa_pkg::*;

  // table state
  logic [SIZE_BITS-1:0]  part_size [PARTITIONS];
  logic [PARTITIONS-1:0] occupied;
  logic [TOT_W-1:0]      internal_sum;

  // latched item
  logic [OP_W-1:0]       op_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [AMOUNT_W-1:0]   amount_q;

  // scan state
  logic [IDX_BITS-1:0]   idx;
  logic [ACC_BITS-1:0]   acc;
  logic                  found;
  logic [IDX_BITS-1:0]   best_idx;
  logic [SIZE_BITS-1:0]  best_size;
  logic [SIZE_BITS-1:0]  best_left;

  logic [SIZE_BITS-1:0]  cur_size;
  logic                  cur_free;
  logic                  better;
  logic                  slot_ok;
  logic [IDX_BITS-1:0]   slot_idx;
  logic                  grant;
  logic [INS_W-1:0]      internal_wide;
  logic [TOT_W-1:0]      internal_next;
  logic [ACC_BITS-1:0]   ext_raw;
  logic [TOT_W-1:0]      ext_sat;

  assign cur_size = part_size[idx];
  assign cur_free = !occupied[idx];
  assign better   = cur_free && (CMP_W'(cur_size) >= CMP_W'(amount_q))
                    && (!found || cur_size > best_size);

  assign slot_ok  = (32'(slot_q) < PARTITIONS);
  assign slot_idx = IDX_BITS'(slot_q);

  assign status.scan_last = (idx == IDX_BITS'(PARTITIONS - 1));

  assign grant = (op_q == OP_ALLOC) && found;

  assign internal_wide = INS_W'(internal_sum) + INS_W'(best_left);
  assign internal_next = (internal_wide > INS_W'(TOTAL_MAX)) ? TOT_W'(TOTAL_MAX)
                                                             : TOT_W'(internal_wide);

  // the chosen partition leaves the free sum on a grant
  assign ext_raw = acc - (grant ? ACC_BITS'(best_size) : ACC_BITS'(0));
  assign ext_sat = (EXT_W'(ext_raw) > EXT_W'(TOTAL_MAX)) ? TOT_W'(TOTAL_MAX)
                                                         : TOT_W'(ext_raw);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PARTITIONS; i++) begin
        part_size[i] <= '0;
      end
      occupied     <= '0;
      internal_sum <= '0;
    end else begin
      if (cmd.apply) begin
        case (op_q)
          OP_LOAD: begin
            if (slot_ok) begin
              part_size[slot_idx] <= SIZE_BITS'(amount_q);
              occupied[slot_idx]  <= 1'b0;
            end
          end
          OP_CLEAR: begin
            occupied     <= '0;
            internal_sum <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.commit && grant) begin
        occupied[best_idx]  <= 1'b1;
        part_size[best_idx] <= best_left;
        internal_sum        <= internal_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q     <= op;
      slot_q   <= slot;
      amount_q <= amount;
      idx      <= '0;
      acc      <= '0;
      found    <= 1'b0;
    end else if (cmd.scan_step) begin
      idx <= idx + IDX_BITS'(1);
      acc <= acc + (cur_free ? ACC_BITS'(cur_size) : ACC_BITS'(0));
      if (better) begin
        found     <= 1'b1;
        best_idx  <= idx;
        best_size <= cur_size;
        best_left <= cur_size - SIZE_BITS'(amount_q);
      end
    end
    if (cmd.commit) begin
      res_granted  <= grant;
      res_chosen   <= grant ? CHOSEN_W'(best_idx) : '0;
      res_leftover <= grant ? LEFT_W'(best_left) : '0;
      res_internal <= grant ? internal_next : internal_sum;
      res_external <= ext_sat;
    end
  end

  `WFPA_ASSERT_ALWAYS(a_internal_range, internal_sum <= TOT_W'(TOTAL_MAX), "internal total range")
  `WFPA_ASSERT_IMP(a_grant_fits, cmd.commit && grant, best_size >= best_left, "grant underflow")

endmodule

`default_nettype wire

// File: rtl/worst_fit_partition_allocator_top.sv
// ----------------------------------------------------------------------------
// worst_fit_partition_allocator_top
// worst-fit allocator over a small table of fixed memory partitions
// ----------------------------------------------------------------------------
// Each input transfer carries one operation in s_tuser: load a partition size
// (the partition becomes free), request an allocation, report the totals, or
// clear all occupied marks together with the internal fragmentation total.
// A request takes the largest free partition that can hold the amount, lowest
// index on a tie, marks it occupied and shrinks it by the amount; the leftover
// goes into a saturating internal total. Every operation yields exactly one
// output transfer holding the grant flag, chosen index, leftover, internal
// total and external total (sum of free sizes after the operation, saturating).
// Timing: one item at a time. A request or report goes from acceptance through
// the scan to the commit into the output register; a load or clear first passes
// an apply step. The scan visits one partition table entry per cycle. A new
// item is accepted as soon as the previous one is in the output register, even
// while that result still waits for m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module worst_fit_partition_allocator_top (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [wfpa_pkg::S_TDATA_W-1:0]    s_tdata,   // slot[2:0], amount[18:3], zero fill
  input  logic [wfpa_pkg::S_TUSER_W-1:0]    s_tuser,   // op[1:0]
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [wfpa_pkg::M_TDATA_W-1:0]    m_tdata,   // chosen[2:0], leftover[18:3],
                                                       // internal_total[37:19],
                                                       // external_total[56:38], zero fill
  output logic [wfpa_pkg::M_TUSER_W-1:0]    m_tuser    // granted[0]
);
  import wfpa_pkg::*;

  wfpa_cmd_t    cmd;
  wfpa_status_t status;

  logic                res_granted;
  logic [CHOSEN_W-1:0] res_chosen;
  logic [LEFT_W-1:0]   res_leftover;
  logic [TOT_W-1:0]    res_internal;
  logic [TOT_W-1:0]    res_external;

  // sequencer: intake, optional table update, scan, commit into output register
  wfpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (s_tuser[OP_W-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // partition table, worst-fit search and free-space sum
  wfpa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .op           (s_tuser[OP_W-1:0]),
    .slot         (s_tdata[SLOT_W-1:0]),
    .amount       (s_tdata[SLOT_W+AMOUNT_W-1:SLOT_W]),
    .res_granted  (res_granted),
    .res_chosen   (res_chosen),
    .res_leftover (res_leftover),
    .res_internal (res_internal),
    .res_external (res_external)
  );

  // pack result fields, lowest field first
  assign m_tdata = {M_PAD_W'(1'b0), res_external, res_internal, res_leftover, res_chosen};
  assign m_tuser = res_granted;

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the worst-fit partition allocator
// ----------------------------------------------------------------------------
// Drives operations into the input stream and predicts every result with a
// local copy of the partition table: sizes, occupied marks and the fragment
// total. Each output transfer is checked field by field against the oldest
// prediction. Directed items come first: ties, zero requests, refusals and
// saturation of the totals. Random traffic follows, shaped as realistic
// load/request sequences with some noise. Sender gaps, receiver stalls, a
// long receiver hold-off and a full drain pause are all part of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import wfpa_pkg::*;

  localparam int S_PAD_W         = S_TDATA_W - SLOT_W - AMOUNT_W;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES   = 30;

  typedef logic [OP_W-1:0]     op_code_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [AMOUNT_W-1:0] amount_t;

  // one result transfer, unpacked
  typedef struct packed {
    logic                granted;
    logic [CHOSEN_W-1:0] chosen;
    logic [LEFT_W-1:0]   leftover;
    logic [TOT_W-1:0]    internal_total;
    logic [TOT_W-1:0]    external_total;
  } alloc_result_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_style_t;

  // clock, reset and block inputs, all known from time zero
  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [S_TUSER_W-1:0] s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  // shadow of the partition table
  logic [SIZE_BITS-1:0] part_size [PARTITIONS];
  logic                 part_busy [PARTITIONS];
  logic [TOT_W:0]       frag_sum;

  // results still owed by the block, oldest first
  alloc_result_t pending_results[$];

  // sender pacing
  int tx_gap_max = 0;
  int tx_burst_left = 0;

  // receiver pacing
  rx_style_t rx_style = RX_ALWAYS;
  int        rx_stall_left = 0;
  int        rx_phase = 0;
  logic      rx_holding = 1'b0;
  event      rx_hold_go;

  // bookkeeping
  int fail_count = 0;
  int mismatch_reports = 0;
  int idle_cycles = 0;
  int n_load = 0, n_report = 0, n_clear = 0;
  int n_granted = 0, n_refused = 0, n_frag_pinned = 0, n_holdoffs = 0;

  worst_fit_partition_allocator_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // predictor: applies one operation to the shadow table, returns the result
  // --------------------------------------------------------------------------
  function automatic alloc_result_t predict_partition_op(op_code_t op, slot_t slot,
                                                         amount_t amount);
    alloc_result_t r;
    int            best;
    logic [TOT_W+1:0] free_sum;
    r    = '0;
    best = -1;
    case (op)
      OP_LOAD: begin
        if (slot < PARTITIONS) begin
          part_size[slot] = SIZE_BITS'(amount);
          part_busy[slot] = 1'b0;
        end
      end
      OP_ALLOC: begin
        // largest free partition that fits, strict compare keeps lowest index
        for (int j = 0; j < PARTITIONS; j++) begin
          if (!part_busy[j] && part_size[j] >= amount) begin
            if (best < 0 || part_size[j] > part_size[best]) best = j;
          end
        end
        if (best >= 0) begin
          part_busy[best]  = 1'b1;
          part_size[best]  = part_size[best] - amount;
          r.granted        = 1'b1;
          r.chosen         = CHOSEN_W'(best);
          r.leftover       = LEFT_W'(part_size[best]);
          frag_sum         = frag_sum + part_size[best];
          if (frag_sum > TOTAL_MAX) begin
            frag_sum = TOTAL_MAX;
            n_frag_pinned++;
          end
        end
      end
      OP_CLEAR: begin
        for (int j = 0; j < PARTITIONS; j++) part_busy[j] = 1'b0;
        frag_sum = '0;
      end
      default: ;  // report leaves the table alone
    endcase
    // external total is the saturated sum of free sizes, on every operation
    free_sum = '0;
    for (int j = 0; j < PARTITIONS; j++) begin
      if (!part_busy[j]) free_sum = free_sum + part_size[j];
    end
    if (free_sum > TOTAL_MAX) free_sum = TOTAL_MAX;
    r.internal_total = frag_sum[TOT_W-1:0];
    r.external_total = free_sum[TOT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // sender: one item per call, bursts of random length with gaps between
  // --------------------------------------------------------------------------
  task automatic send_op(op_code_t op, slot_t slot, amount_t amount);
    alloc_result_t r;
    int            gap;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 24);
      gap = (tx_gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 :
            $urandom_range(1, tx_gap_max);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    tx_burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{S_PAD_W{1'b0}}, amount, slot};
    // hold the item until the transfer happens
    do @(posedge clk); while (!s_tready);
    r = predict_partition_op(op, slot, amount);
    pending_results.push_back(r);
    case (op)
      OP_LOAD:   n_load++;
      OP_ALLOC:  if (r.granted) n_granted++; else n_refused++;
      OP_REPORT: n_report++;
      default:   n_clear++;
    endcase
  endtask

  // drop valid and wait for every owed result
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    tx_burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // request sizes, some of them aimed at the current table contents
  function automatic amount_t pick_amount();
    int k;
    k = $urandom_range(0, PARTITIONS - 1);
    case ($urandom_range(0, 6))
      0:       return amount_t'($urandom_range(0, 65535));
      1:       return amount_t'($urandom_range(0, 15));
      2:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      3:       return part_size[k] - amount_t'($urandom_range(0, 3));
      4:       return part_size[k];
      5:       return part_size[k] + 1'b1;
      default: return amount_t'($urandom_range(49152, 65535));
    endcase
  endfunction

  // mostly well-formed load/request traffic, the rest is noise
  task automatic send_random_op();
    int      roll;
    amount_t amt;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      send_op(op_code_t'($urandom_range(0, 3)), slot_t'($urandom_range(0, 7)),
              amount_t'($urandom_range(0, 65535)));
    end else if (roll < 42) begin
      // tie-prone sizes now and then
      amt = ($urandom_range(0, 3) == 0) ? amount_t'(16'h1000 << $urandom_range(0, 3))
                                        : pick_amount();
      send_op(OP_LOAD, slot_t'($urandom_range(0, 7)), amt);
    end else if (roll < 87) begin
      send_op(OP_ALLOC, slot_t'($urandom_range(0, 7)), pick_amount());
    end else if (roll < 96) begin
      send_op(OP_REPORT, slot_t'($urandom_range(0, 7)), amount_t'($urandom_range(0, 65535)));
    end else begin
      send_op(OP_CLEAR, slot_t'($urandom_range(0, 7)), amount_t'($urandom_range(0, 65535)));
    end
  endtask

  // --------------------------------------------------------------------------
  // receiver: own stall pattern, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_holding) begin
      m_tready <= 1'b0;
    end else begin
      case (rx_style)
        RX_ALWAYS:   m_tready <= 1'b1;
        RX_PERIODIC: m_tready <= (rx_phase % 7) < 4;
        default: begin
          if (rx_stall_left > 0) begin
            m_tready      <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
          end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 4) == 0) rx_stall_left <= $urandom_range(1, 8);
          end
        end
      endcase
    end
  end

  // hold-off length counted here, independent of the sender
  always begin
    @(rx_hold_go);
    rx_holding <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(negedge clk);
    rx_holding <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // result checker: every output transfer against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    alloc_result_t seen;
    alloc_result_t owed;
    if (!rst && m_tvalid && m_tready) begin
      seen.granted        = m_tuser[0];
      seen.chosen         = m_tdata[2:0];
      seen.leftover       = m_tdata[18:3];
      seen.internal_total = m_tdata[37:19];
      seen.external_total = m_tdata[56:38];
      if (pending_results.size() == 0) begin
        fail_count++;
        if (mismatch_reports < 10) begin
          $display("unexpected result transfer: g=%0d chosen=%0d left=%0d int=%0d ext=%0d",
                   seen.granted, seen.chosen, seen.leftover, seen.internal_total,
                   seen.external_total);
          mismatch_reports++;
        end
      end else begin
        owed = pending_results.pop_front();
        if (seen !== owed) begin
          fail_count++;
          if (mismatch_reports < 10) begin
            $display("mismatch: want g=%0d chosen=%0d left=%0d int=%0d ext=%0d",
                     owed.granted, owed.chosen, owed.leftover, owed.internal_total,
                     owed.external_total);
            $display("          got  g=%0d chosen=%0d left=%0d int=%0d ext=%0d",
                     seen.granted, seen.chosen, seen.leftover, seen.internal_total,
                     seen.external_total);
            mismatch_reports++;
          end
        end
      end
    end
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("no transfer for %0d cycles", idle_cycles);
      $display("[worst_fit_partition_allocator_top] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // every operation, tie on equal sizes, zero request, refusal
  task automatic test_ops_and_ties();
    send_op(OP_REPORT, 3'd0, 16'd0);        // totals straight out of reset
    send_op(OP_ALLOC, 3'd7, 16'd0);         // zero request on an empty table takes slot 0
    send_op(OP_LOAD, 3'd0, 16'hFFFF);       // frees slot 0 again
    send_op(OP_LOAD, 3'd5, 16'hFFFF);
    send_op(OP_LOAD, 3'd2, 16'd1);
    send_op(OP_LOAD, 3'd3, 16'h8000);
    send_op(OP_ALLOC, 3'd0, 16'hFFFF);      // tie, lowest index wins
    send_op(OP_ALLOC, 3'd0, 16'hFFFF);      // the other one of the pair
    send_op(OP_ALLOC, 3'd0, 16'hFFFF);      // nothing fits
    send_op(OP_ALLOC, 3'd0, 16'd0);         // whole partition is leftover
    send_op(OP_ALLOC, 3'd0, 16'd2);         // refused, nothing that large left
    send_op(OP_CLEAR, 3'd7, 16'hFFFF);
  endtask

  // full table for the external ceiling, then push internal past it
  task automatic test_total_saturation();
    for (int j = 0; j < PARTITIONS; j++) send_op(OP_LOAD, slot_t'(j), 16'hFFFF);
    for (int j = 0; j < PARTITIONS; j++) send_op(OP_ALLOC, 3'd0, 16'd0);
    send_op(OP_LOAD, 3'd4, 16'hFFFF);
    send_op(OP_ALLOC, 3'd0, 16'd0);         // internal total pinned
  endtask

  // random traffic in chunks, pacing changes per chunk
  task automatic test_random_traffic();
    for (int chunk = 0; chunk < 11; chunk++) begin
      rx_style   = rx_style_t'($urandom_range(0, 2));
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
      repeat (100) send_random_op();
      if (chunk % 4 == 3) drain_results();
    end
  endtask

  // long receiver hold-off while the sender keeps offering items
  task automatic test_receiver_holdoff();
    rx_style   = RX_RANDOM;
    tx_gap_max = 0;
    -> rx_hold_go;
    n_holdoffs++;
    repeat (60) send_random_op();
  endtask

  // sender stops until every result is back, a few times over
  task automatic test_sender_pause();
    rx_style   = RX_PERIODIC;
    tx_gap_max = 4;
    repeat (5) begin
      repeat (12) send_random_op();
      drain_results();
    end
  endtask

  // back-to-back items with no stalls on either side
  task automatic test_unthrottled_stream();
    rx_style   = RX_ALWAYS;
    tx_gap_max = 0;
    repeat (200) send_random_op();
  endtask

  initial begin
    for (int j = 0; j < PARTITIONS; j++) begin
      part_size[j] = '0;
      part_busy[j] = 1'b0;
    end
    frag_sum = '0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_ops_and_ties();
    test_total_saturation();
    test_random_traffic();
    test_receiver_holdoff();
    test_sender_pause();
    test_unthrottled_stream();

    // let the last results come out, then watch for strays
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    fail_count += pending_results.size();

    $display("ran %0d loads, %0d requests (%0d granted, %0d refused), %0d reports, %0d clears",
             n_load, n_granted + n_refused, n_granted, n_refused, n_report, n_clear);
    $display("internal total pinned %0d times, %0d long hold-offs, %0d failures",
             n_frag_pinned, n_holdoffs, fail_count);
    if (fail_count == 0) begin
      $display("[worst_fit_partition_allocator_top] OK");
    end else begin
      $display("[worst_fit_partition_allocator_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
